// File: hdl/ci32_pkg.sv
// Package for the checked 32-bit integer ALU: opcodes, error codes and word types.
// Depends on nothing; used by every module under hdl.
package ci32_pkg;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
        OP_POW = 5'd5, OP_NEG = 5'd6, OP_EQ = 5'd7, OP_NE = 5'd8, OP_LT = 5'd9,
        OP_GT = 5'd10, OP_LE = 5'd11, OP_GE = 5'd12, OP_AND = 5'd13, OP_OR = 5'd14,
        OP_ABS = 5'd15, OP_MAX = 5'd16, OP_MIN = 5'd17, OP_CHAR = 5'd18
    } opcode_t;

    localparam logic [2:0] ERR_OK     = 3'd0;
    localparam logic [2:0] ERR_OVF    = 3'd1;
    localparam logic [2:0] ERR_DIV0   = 3'd2;
    localparam logic [2:0] ERR_NEGPOW = 3'd3;
    localparam logic [2:0] ERR_CHAR   = 3'd4;

    typedef struct packed {
        logic [4:0]         command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic [2:0]         error;
    } out_word_t;

    // Classified work handed from front to back.
    typedef enum logic [2:0] {
        K_DONE = 3'b001,   // answer already known
        K_DIV  = 3'b010,   // div or mod through the serial divider
        K_POW  = 3'b100    // square-and-multiply
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        is_mod;
        logic [31:0] a;
        logic [31:0] b;
        out_word_t   done;
    } job_t;

endpackage

// File: hdl/checked_int32_alu.sv
// Top level of the overflow-checked 32-bit integer ALU.
// Depends on ci32_pkg, ci32_front, ci32_queue and ci32_back.
//
//  channel   | handshake      | payload
//  ----------+----------------+----------------------------------
//  command   | start / busy   | in  : command, operand_a, operand_b
//  result    | done (strobe)  | out : result, error
//
// Path of a word: simple ops pass the front register, the queue write and the
// back end output register. Div and mod: the back end's restoring divider runs
// one quotient bit per cycle, then a final state signs and checks the answer.
// Pow: each square or multiply uses the back end's one multiplier. The longest
// run is base 0 or +-1 with exponent 2^31-1 (61 steps), while larger bases stop
// at the first overflow. Reset clears all control state; busy rises only when
// the queue is full and the front register holds a word.
// The receiver cannot stall: each result shows for one cycle on done.
module checked_int32_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ci32_pkg::in_word_t  operands,
    output logic                done,
    output ci32_pkg::out_word_t answer
);
    logic           push, full, pop, avail;
    ci32_pkg::job_t push_job, pop_job;

    // Front: classify and finish quick ops.
    ci32_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .word  (operands),
        .busy  (busy),
        .push  (push),
        .job   (push_job),
        .full  (full)
    );

    // Hold jobs while the back end iterates.
    ci32_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .avail    (avail),
        .pop_job  (pop_job)
    );

    // Back: iterate divides and powers, drive the strobe.
    ci32_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .avail (avail),
        .job   (pop_job),
        .pop   (pop),
        .done  (done),
        .word  (answer)
    );
endmodule

// File: hdl/ci32_front.sv
// Front end: accepts words and classifies them; quick ops are finished here.
// Depends on ci32_pkg.
module ci32_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ci32_pkg::in_word_t word,
    output logic               busy,
    output logic               push,
    output ci32_pkg::job_t     job,
    input  logic               full
);
    // Multiply is registered in stage one, checked in stage two.
    logic                   s1_valid_reg;
    ci32_pkg::in_word_t     s1_word_reg;
    logic signed [63:0]     s1_prod_reg;
    logic signed [32:0]     a_x, b_x, sum_x, dif_x, neg_x;
    logic signed [33:0]     r_x;
    logic [2:0]             err;
    logic                   neg_a, is_out;

    assign busy = s1_valid_reg && full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!busy)
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy && start)
        begin
            s1_word_reg <= word;
            s1_prod_reg <= word.operand_a * word.operand_b;
        end
    end

    always_comb
    begin
        a_x   = 33'(s1_word_reg.operand_a);
        b_x   = 33'(s1_word_reg.operand_b);
        sum_x = a_x + b_x;
        dif_x = a_x - b_x;
        neg_x = -a_x;
        neg_a = s1_word_reg.operand_a < 0;
        r_x   = '0;
        err   = ci32_pkg::ERR_OK;
        job.kind   = ci32_pkg::K_DONE;
        job.is_mod = s1_word_reg.command == ci32_pkg::OP_MOD;
        job.a      = s1_word_reg.operand_a;
        job.b      = s1_word_reg.operand_b;
        case (s1_word_reg.command)
            ci32_pkg::OP_ADD: r_x = 34'(sum_x);
            ci32_pkg::OP_SUB: r_x = 34'(dif_x);
            ci32_pkg::OP_MUL:
            begin
                r_x = 34'(s1_prod_reg[31:0] & 32'h0);
                if (s1_prod_reg[63:31] != {33{s1_prod_reg[31]}})
                begin
                    err = ci32_pkg::ERR_OVF;
                end
                r_x = 34'(signed'(s1_prod_reg[31:0]));
            end
            ci32_pkg::OP_DIV, ci32_pkg::OP_MOD:
            begin
                if (s1_word_reg.operand_b == 0)
                begin
                    err = ci32_pkg::ERR_DIV0;
                end
                else
                begin
                    job.kind = ci32_pkg::K_DIV;
                end
            end
            ci32_pkg::OP_POW:
            begin
                if (s1_word_reg.operand_b < 0)
                begin
                    err = ci32_pkg::ERR_NEGPOW;
                end
                else
                begin
                    job.kind = ci32_pkg::K_POW;
                end
            end
            ci32_pkg::OP_NEG: r_x = 34'(neg_x);
            ci32_pkg::OP_EQ:  r_x = 34'(s1_word_reg.operand_a == s1_word_reg.operand_b);
            ci32_pkg::OP_NE:  r_x = 34'(s1_word_reg.operand_a != s1_word_reg.operand_b);
            ci32_pkg::OP_LT:  r_x = 34'(s1_word_reg.operand_a < s1_word_reg.operand_b);
            ci32_pkg::OP_GT:  r_x = 34'(s1_word_reg.operand_a > s1_word_reg.operand_b);
            ci32_pkg::OP_LE:  r_x = 34'(s1_word_reg.operand_a <= s1_word_reg.operand_b);
            ci32_pkg::OP_GE:  r_x = 34'(s1_word_reg.operand_a >= s1_word_reg.operand_b);
            ci32_pkg::OP_AND:
                r_x = 34'(s1_word_reg.operand_a != 0 && s1_word_reg.operand_b != 0);
            ci32_pkg::OP_OR:
                r_x = 34'(s1_word_reg.operand_a != 0 || s1_word_reg.operand_b != 0);
            ci32_pkg::OP_ABS: r_x = neg_a ? 34'(neg_x) : 34'(a_x);
            ci32_pkg::OP_MAX: r_x = 34'(s1_word_reg.operand_a > s1_word_reg.operand_b
                                        ? a_x : b_x);
            ci32_pkg::OP_MIN: r_x = 34'(s1_word_reg.operand_a < s1_word_reg.operand_b
                                        ? a_x : b_x);
            ci32_pkg::OP_CHAR:
            begin
                if (neg_a || s1_word_reg.operand_a > 255)
                begin
                    err = ci32_pkg::ERR_CHAR;
                end
                r_x = 34'(a_x);
            end
            default: r_x = '0;
        endcase
        is_out = r_x[33:31] != {3{r_x[31]}};
        if (err == ci32_pkg::ERR_OK && is_out)
        begin
            err = ci32_pkg::ERR_OVF;
        end
        job.done.error  = err;
        job.done.result = (err == ci32_pkg::ERR_OK) ? r_x[31:0] : 32'sd0;
        push = s1_valid_reg && !full;
    end
endmodule

// File: hdl/ci32_queue.sv
// Two-entry queue of classified jobs between front and back end.
// Depends on ci32_pkg.
module ci32_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ci32_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output ci32_pkg::job_t pop_job
);
    ci32_pkg::job_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;

    assign full    = cnt_reg == 2'd2;
    assign avail   = cnt_reg != 2'd0;
    assign pop_job = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_job;
        end
    end
endmodule

// File: hdl/ci32_back.sv
// Back end: serial divider and square-and-multiply power unit; drives the result strobe.
// Depends on ci32_pkg.
module ci32_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                avail,
    input  ci32_pkg::job_t      job,
    output logic                pop,
    output logic                done,
    output ci32_pkg::out_word_t word
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_POW  = 5'b00100,
        S_PMUL = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t        state_reg;
    logic [5:0]    cnt_reg;
    logic [31:0]   rem_reg, quo_reg, dvs_reg;
    logic          neg_q_reg, neg_r_reg, mod_reg;
    logic [31:0]   exp_reg;
    logic signed [31:0] base_reg, acc_reg;
    logic          base_ok_reg, ovf_reg;
    logic signed [63:0] prod_reg;
    logic          prod_sq_reg;
    logic          done_reg;
    ci32_pkg::out_word_t word_reg;
    logic [32:0]   trial;
    logic [31:0]   rem_sh;
    logic          prod_fits;
    logic [32:0]   q_fin;
    logic [31:0]   r_fin;

    assign done = done_reg;
    assign word = word_reg;
    assign pop  = avail && state_reg == S_IDLE;

    always_comb
    begin
        rem_sh    = {rem_reg[30:0], quo_reg[31]};
        trial     = {1'b0, rem_sh} - {1'b0, dvs_reg};
        prod_fits = prod_reg[63:31] == {33{prod_reg[31]}};
        q_fin     = neg_q_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};
        r_fin     = neg_r_reg ? -rem_reg : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (avail)
                    begin
                        case (job.kind)
                            ci32_pkg::K_DIV: state_reg <= S_DIV;
                            ci32_pkg::K_POW: state_reg <= S_POW;
                            default:         done_reg  <= 1'b1;
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == 6'd31)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_POW:
                begin
                    if (exp_reg == 0 || ovf_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_PMUL;
                    end
                end
                S_PMUL:    state_reg <= S_POW;
                S_FIN:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                word_reg    <= job.done;
                cnt_reg     <= '0;
                mod_reg     <= job.is_mod;
                neg_q_reg   <= job.a[31] ^ job.b[31];
                neg_r_reg   <= job.a[31];
                rem_reg     <= '0;
                quo_reg     <= job.a[31] ? -job.a : job.a;
                dvs_reg     <= job.b[31] ? -job.b : job.b;
                exp_reg     <= job.b;
                base_reg    <= job.a;
                acc_reg     <= 32'sd1;
                base_ok_reg <= 1'b1;
                ovf_reg     <= 1'b0;
                prod_sq_reg <= 1'b0;
            end
            S_DIV:
            begin
                // Restoring divide, one quotient bit per cycle.
                cnt_reg <= cnt_reg + 6'd1;
                if (!trial[32])
                begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
            end
            S_POW:
            begin
                // Multiply acc by base on an odd exponent bit, else square the base.
                if (exp_reg[0])
                begin
                    prod_reg    <= acc_reg * base_reg;
                    prod_sq_reg <= 1'b0;
                end
                else
                begin
                    prod_reg    <= base_reg * base_reg;
                    prod_sq_reg <= 1'b1;
                end
            end
            S_PMUL:
            begin
                if (!prod_sq_reg)
                begin
                    // acc never shrinks once |base| >= 2, so a bad base poisons it.
                    if (!prod_fits || !base_ok_reg)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    acc_reg <= prod_reg[31:0];
                    exp_reg <= exp_reg - 32'd1;
                end
                else
                begin
                    if (!prod_fits)
                    begin
                        base_ok_reg <= 1'b0;
                    end
                    base_reg <= prod_reg[31:0];
                    exp_reg  <= {1'b0, exp_reg[31:1]};
                end
            end
            S_FIN:
            begin
                if (!mod_reg && dvs_reg != 0 && cnt_reg == 6'd32)
                begin
                    if (q_fin[32] != q_fin[31])
                    begin
                        word_reg.error  <= ci32_pkg::ERR_OVF;
                        word_reg.result <= '0;
                    end
                    else
                    begin
                        word_reg.result <= q_fin[31:0];
                    end
                end
                else if (cnt_reg == 6'd32)
                begin
                    word_reg.result <= r_fin;
                end
                else if (ovf_reg)
                begin
                    word_reg.error  <= ci32_pkg::ERR_OVF;
                    word_reg.result <= '0;
                end
                else
                begin
                    word_reg.result <= acc_reg;
                end
            end
            default: ;
        endcase
    end
endmodule
